// ----- src/keypad_entry_count_timer_macros.svh -----
// ============================================================================
// Keypad entry count timer assertion macros
// Shared assertion forms for the keypad entry count timer modules.
// ============================================================================
`ifndef KEYPAD_ENTRY_COUNT_TIMER_MACROS_SVH
`define KEYPAD_ENTRY_COUNT_TIMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KECT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/kect_pkg.sv -----
// ============================================================================
// Keypad entry count timer package
// Shared types, codes, reset values and the digit split helper.
// ============================================================================
package kect_pkg;

    // Run modes, as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DOWN  = 2'd1,
        MODE_UP    = 2'd2,
        MODE_FLASH = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_TICKS     = 2'd0;
    localparam logic [1:0] CFG_FLASH_TICKS    = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd2;
    localparam logic [1:0] CFG_FLASH_REPEATS  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] STEP_TICKS_RST     = 16'd1000;
    localparam logic [15:0] FLASH_TICKS_RST    = 16'd400;
    localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd100;
    localparam logic [3:0]  FLASH_REPEATS_RST  = 4'd6;

    // Key codes with a meaning of their own.
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_A          = 4'd10;
    localparam logic [3:0] KEY_B          = 4'd11;
    localparam logic [3:0] KEY_HASH       = 4'd15;

    // Command codes.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Digit code that leaves a display position dark.
    localparam logic [3:0] DIGIT_BLANK = 4'hF;

    // Saturation point of the time since the last key.
    localparam logic [15:0] SINCE_MAX = 16'hFFFF;

    // Configuration as seen by the counting logic.
    typedef struct packed {
        logic [15:0] step_ticks;
        logic [15:0] flash_ticks;
        logic [15:0] debounce_ticks;
        logic [3:0]  flash_repeats;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [3:0] tens_digit;
        logic [3:0] ones_digit;
        logic       led_on;
        t_mode      run_mode;
        logic [1:0] entry_digits;
        logic [6:0] entry_value;
    } t_result;

    // Shown digits of a value of at most 99.
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } t_digits;

    // Splits a value into display digits; a zero tens digit is blanked.
    // The tens come from a multiply by 205/2048, exact for all 7-bit values.
    function automatic t_digits split_digits(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rem;
        t_digits     res;
        prod = 15'(value) * 15'd205;
        tens = prod[14:11];
        rem = value - 7'(tens) * 7'd10;
        res.tens = (tens != 4'd0) ? tens : DIGIT_BLANK;
        res.ones = rem[3:0];
        return res;
    endfunction

endpackage

// ----- src/kect_ifs.sv -----
// ============================================================================
// Keypad entry count timer channels
// Valid/ready interfaces for key and tick events, results and configuration.
// ============================================================================

// Input events: a key press or a one-millisecond tick.
interface kect_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] key_code;

    modport source (output valid, command, key_code, input ready);
    modport sink   (input valid, command, key_code, output ready);
endinterface

// Result items: the display and status after each event.
interface kect_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] tens_digit;
    logic [3:0] ones_digit;
    logic       led_on;
    logic [1:0] run_mode;
    logic [1:0] entry_digits;
    logic [6:0] entry_value;

    modport source (output valid, tens_digit, ones_digit, led_on, run_mode,
                    entry_digits, entry_value, input ready);
    modport sink   (input valid, tens_digit, ones_digit, led_on, run_mode,
                    entry_digits, entry_value, output ready);
endinterface

// Configuration register writes.
interface kect_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/kect_cfg.sv -----
// ============================================================================
// Keypad entry count timer configuration registers
// Holds the step, flash and debounce times and the flash repeat count.
// ============================================================================
module kect_cfg
    import kect_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kect_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register file with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ticks     <= STEP_TICKS_RST;
            r_cfg.flash_ticks    <= FLASH_TICKS_RST;
            r_cfg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_cfg.flash_repeats  <= FLASH_REPEATS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STEP_TICKS:     r_cfg.step_ticks     <= i_cfg.data;
                CFG_FLASH_TICKS:    r_cfg.flash_ticks    <= i_cfg.data;
                CFG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg.data;
                CFG_FLASH_REPEATS:  r_cfg.flash_repeats  <= i_cfg.data[3:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/kect_core.sv -----
// ============================================================================
// Keypad entry count timer core
// Entry, debounce, count and flash state, updated once per event.
// ============================================================================
module kect_core
    import kect_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_command,
    input  logic [3:0] i_key_code,
    input  t_cfg       i_cfg,
    output t_result    o_next
);

    `include "keypad_entry_count_timer_macros.svh"

    // State registers.
    logic [6:0]  r_entry_number, n_entry_number;
    logic [1:0]  r_entry_count,  n_entry_count;
    logic        r_last_valid,   n_last_valid;
    logic [3:0]  r_last_key,     n_last_key;
    logic [15:0] r_since,        n_since;
    t_mode       r_mode,         n_mode;
    logic [6:0]  r_count_value,  n_count_value;
    logic [6:0]  r_count_target, n_count_target;
    logic [15:0] r_phase_timer,  n_phase_timer;
    logic [4:0]  r_flash_phase,  n_flash_phase;
    logic        r_led,          n_led;
    logic [3:0]  r_shown_tens,   n_shown_tens;
    logic [3:0]  r_shown_ones,   n_shown_ones;

    // Helper terms.
    logic        w_key_accept;
    logic [6:0]  w_digit_value;
    logic [15:0] w_limit;
    logic [16:0] w_phase_inc;
    logic        w_phase_done;
    logic [5:0]  w_flash_inc;
    logic [6:0]  w_count_dec;
    logic [6:0]  w_count_inc;
    t_digits     w_start_digits;
    t_digits     w_dec_digits;
    t_digits     w_inc_digits;
    t_digits     w_final_digits;

    // A repeated key passes only once the debounce time has gone by.
    assign w_key_accept = !r_last_valid || (r_last_key != i_key_code) ||
                          (r_since > i_cfg.debounce_ticks);

    // Entry times ten plus the new digit.
    assign w_digit_value = 7'({r_entry_number, 3'b000}) + 7'({r_entry_number, 1'b0}) +
                           7'(i_key_code);

    // Phase length of the current mode, zero treated as one.
    always_comb begin
        w_limit = (r_mode == MODE_FLASH) ? i_cfg.flash_ticks : i_cfg.step_ticks;
        if (w_limit == 16'd0) begin
            w_limit = 16'd1;
        end
    end

    assign w_phase_inc  = 17'(r_phase_timer) + 17'd1;
    assign w_phase_done = w_phase_inc >= 17'(w_limit);
    assign w_flash_inc  = 6'(r_flash_phase) + 6'd1;
    assign w_count_dec  = r_count_value - 7'd1;
    assign w_count_inc  = r_count_value + 7'd1;

    assign w_start_digits = split_digits(r_entry_number);
    assign w_dec_digits   = split_digits(w_count_dec);
    assign w_inc_digits   = split_digits(w_count_inc);
    assign w_final_digits = split_digits(r_count_value);

    // Next state for one event.
    always_comb begin
        n_entry_number = r_entry_number;
        n_entry_count  = r_entry_count;
        n_last_valid   = r_last_valid;
        n_last_key     = r_last_key;
        n_since        = r_since;
        n_mode         = r_mode;
        n_count_value  = r_count_value;
        n_count_target = r_count_target;
        n_phase_timer  = r_phase_timer;
        n_flash_phase  = r_flash_phase;
        n_led          = r_led;
        n_shown_tens   = r_shown_tens;
        n_shown_ones   = r_shown_ones;

        if (i_command == CMD_KEY) begin
            if (w_key_accept) begin
                n_last_valid = 1'b1;
                n_last_key   = i_key_code;
                n_since      = 16'd0;
                if (i_key_code == KEY_HASH) begin
                    n_entry_number = 7'd0;
                    n_entry_count  = 2'd0;
                end else if (i_key_code <= KEY_LAST_DIGIT) begin
                    if (r_entry_count < 2'd2) begin
                        n_entry_number = w_digit_value;
                        n_entry_count  = r_entry_count + 2'd1;
                    end
                end else if ((i_key_code == KEY_A || i_key_code == KEY_B) &&
                             r_entry_count != 2'd0) begin
                    n_entry_number = 7'd0;
                    n_entry_count  = 2'd0;
                    if (r_entry_number != 7'd0) begin
                        n_flash_phase = 5'd0;
                        n_phase_timer = 16'd0;
                        n_led         = !r_led;
                        if (i_key_code == KEY_A) begin
                            n_mode         = MODE_DOWN;
                            n_count_value  = r_entry_number;
                            n_count_target = 7'd0;
                            n_shown_tens   = w_start_digits.tens;
                            n_shown_ones   = w_start_digits.ones;
                        end else begin
                            n_mode         = MODE_UP;
                            n_count_value  = 7'd0;
                            n_count_target = r_entry_number;
                            n_shown_tens   = DIGIT_BLANK;
                            n_shown_ones   = 4'd0;
                        end
                    end
                end
            end
        end else begin
            if (r_since != SINCE_MAX) begin
                n_since = r_since + 16'd1;
            end
            if (r_mode != MODE_IDLE) begin
                if (!w_phase_done) begin
                    n_phase_timer = w_phase_inc[15:0];
                end else begin
                    n_phase_timer = 16'd0;
                    unique case (r_mode)
                        MODE_DOWN: begin
                            if (r_count_value != 7'd0) begin
                                n_count_value = w_count_dec;
                                n_led         = !r_led;
                                n_shown_tens  = w_dec_digits.tens;
                                n_shown_ones  = w_dec_digits.ones;
                            end else begin
                                n_mode        = MODE_FLASH;
                                n_flash_phase = 5'd0;
                                n_shown_tens  = DIGIT_BLANK;
                                n_shown_ones  = DIGIT_BLANK;
                            end
                        end
                        MODE_UP: begin
                            if (r_count_value < r_count_target) begin
                                n_count_value = w_count_inc;
                                n_led         = !r_led;
                                n_shown_tens  = w_inc_digits.tens;
                                n_shown_ones  = w_inc_digits.ones;
                            end else begin
                                n_mode        = MODE_FLASH;
                                n_flash_phase = 5'd0;
                                n_shown_tens  = DIGIT_BLANK;
                                n_shown_ones  = DIGIT_BLANK;
                            end
                        end
                        MODE_FLASH: begin
                            n_flash_phase = w_flash_inc[4:0];
                            if (w_flash_inc >= {1'b0, i_cfg.flash_repeats, 1'b0}) begin
                                n_mode        = MODE_IDLE;
                                n_flash_phase = 5'd0;
                                n_shown_tens  = w_final_digits.tens;
                                n_shown_ones  = w_final_digits.ones;
                            end else if (w_flash_inc[0]) begin
                                n_shown_tens  = w_final_digits.tens;
                                n_shown_ones  = w_final_digits.ones;
                            end else begin
                                n_shown_tens  = DIGIT_BLANK;
                                n_shown_ones  = DIGIT_BLANK;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                end
            end
        end
    end

    // State update on each event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_number <= 7'd0;
            r_entry_count  <= 2'd0;
            r_last_valid   <= 1'b0;
            r_last_key     <= 4'd0;
            r_since        <= 16'd0;
            r_mode         <= MODE_IDLE;
            r_count_value  <= 7'd0;
            r_count_target <= 7'd0;
            r_phase_timer  <= 16'd0;
            r_flash_phase  <= 5'd0;
            r_led          <= 1'b0;
            r_shown_tens   <= DIGIT_BLANK;
            r_shown_ones   <= DIGIT_BLANK;
        end else if (i_step) begin
            r_entry_number <= n_entry_number;
            r_entry_count  <= n_entry_count;
            r_last_valid   <= n_last_valid;
            r_last_key     <= n_last_key;
            r_since        <= n_since;
            r_mode         <= n_mode;
            r_count_value  <= n_count_value;
            r_count_target <= n_count_target;
            r_phase_timer  <= n_phase_timer;
            r_flash_phase  <= n_flash_phase;
            r_led          <= n_led;
            r_shown_tens   <= n_shown_tens;
            r_shown_ones   <= n_shown_ones;
        end
    end

    // Result of the current event, taken by the output register.
    always_comb begin
        o_next.tens_digit   = n_shown_tens;
        o_next.ones_digit   = n_shown_ones;
        o_next.led_on       = n_led;
        o_next.run_mode     = n_mode;
        o_next.entry_digits = n_entry_count;
        o_next.entry_value  = n_entry_number;
    end

    // An empty entry always has the value zero.
    `KECT_ASSERT_NOW(a_empty_entry_zero, r_entry_count == 2'd0, r_entry_number == 7'd0,
        "empty entry holds a nonzero value")
    // A single digit entry never exceeds nine.
    `KECT_ASSERT_NOW(a_one_digit_range, r_entry_count == 2'd1, r_entry_number <= 7'd9,
        "single digit entry out of range")
    // The LED only changes on an event.
    `KECT_ASSERT_NEXT(a_led_hold, !i_step, $stable(r_led),
        "LED changed without an event")
    // The flash phase is cleared whenever the block is idle.
    `KECT_ASSERT_NOW(a_idle_phase, r_mode == MODE_IDLE, r_flash_phase == 5'd0,
        "flash phase left set while idle")

endmodule

// ----- src/keypad_entry_count_timer.sv -----
// ============================================================================
// Keypad entry count timer
// Top level: input register, event core, configuration and result register.
// ============================================================================
// Each key press or millisecond tick is one transaction on the item channel
// and yields exactly one result transaction: the display digits, LED, run
// mode and entry after that event. An event is registered on acceptance,
// moved into the core once the result register is empty or being taken, and
// held in the result register until taken, so one event per clock is
// sustained while results are taken. The item channel stays ready while the
// result register is empty or being taken. Configuration writes are always
// ready and should be made while no event is in flight.
module keypad_entry_count_timer
    import kect_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    kect_cfg_if.sink      i_cfg,
    kect_item_if.sink     i_item,
    kect_result_if.source o_result
);

    logic       r_in_valid;
    logic       r_in_command;
    logic [3:0] r_in_key_code;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    t_cfg       w_cfg;
    t_result    w_next;

    // Move the registered event into the core when the result can be stored.
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_command  <= i_item.command;
            r_in_key_code <= i_item.key_code;
        end
    end

    kect_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    kect_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_command  (r_in_command),
        .i_key_code (r_in_key_code),
        .i_cfg      (w_cfg),
        .o_next     (w_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.tens_digit   = r_out.tens_digit;
    assign o_result.ones_digit   = r_out.ones_digit;
    assign o_result.led_on       = r_out.led_on;
    assign o_result.run_mode     = r_out.run_mode;
    assign o_result.entry_digits = r_out.entry_digits;
    assign o_result.entry_value  = r_out.entry_value;

endmodule

// ----- sim/testbench.sv -----
// ============================================================================
// Keypad entry count timer testbench
// Drives key and tick transactions with random gaps and receiver stalls, and
// predicts every result transaction with a cycle-free model of the timer.
// A short directed table covers entry, debounce, start and flash cases, and
// random phases with changing timing registers cover the rest.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kect_pkg::*;

    // Keys that only get accepted and otherwise do nothing.
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int RANDOM_EVENTS  = 1850;
    localparam int PHASE_EVENTS   = 150;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_AT_RESULT = 120;
    localparam int HOLD_CYCLES    = 300;

    // Kinds of rows in the directed table.
    typedef enum logic {
        ROW_EVENT,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        cmd;
        logic [3:0]  code;
        int          count;
        logic [1:0]  reg_idx;
        logic [15:0] reg_data;
        bit          typed;
        t_result     want;
    } t_row;

    // Predicted state of the timer.
    typedef struct {
        int         entry_number;
        int         entry_count;
        bit         key_valid;
        logic [3:0] key_prev;
        int         since_key;
        t_mode      mode;
        int         cnt_value;
        int         cnt_target;
        int         phase_ticks;
        int         flash_idx;
        logic       led;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_timer_state;

    logic i_clk;
    logic i_rst_n;

    kect_cfg_if    cfg_ch ();
    kect_item_if   item_ch ();
    kect_result_if res_ch ();

    keypad_entry_count_timer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    t_timer_state timer_state;
    t_cfg         timing_regs;
    t_result      predicted_status[$];
    int           events_sent = 0;
    int           failures = 0;
    bit           burst_mode = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random gap length: mostly none, often short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Shows a value with the tens blanked when they are zero.
    function automatic void show_value(int v);
        int t;
        t = (v / 10) % 10;
        timer_state.tens = (t > 0) ? 4'(t) : DIGIT_BLANK;
        timer_state.ones = 4'(v % 10);
    endfunction

    // Shows a new count value, toggles the LED and restarts the step timer.
    function automatic void step_display(int v);
        show_value(v);
        timer_state.led = ~timer_state.led;
        timer_state.phase_ticks = 0;
    endfunction

    function automatic void enter_flash();
        timer_state.mode = MODE_FLASH;
        timer_state.flash_idx = 0;
        timer_state.phase_ticks = 0;
        timer_state.tens = DIGIT_BLANK;
        timer_state.ones = DIGIT_BLANK;
    endfunction

    // Key press: debounce filter, entry building and count start.
    function automatic void predict_key(logic [3:0] k);
        bit take;
        int v;
        take = !timer_state.key_valid || timer_state.key_prev != k ||
               timer_state.since_key > int'(timing_regs.debounce_ticks);
        if (!take) return;
        if (k == KEY_HASH) begin
            timer_state.entry_number = 0;
            timer_state.entry_count = 0;
        end else if (k <= KEY_LAST_DIGIT) begin
            if (timer_state.entry_count < 2) begin
                timer_state.entry_number = timer_state.entry_number * 10 + int'(k);
                timer_state.entry_count++;
            end
        end else if ((k == KEY_A || k == KEY_B) && timer_state.entry_count > 0) begin
            v = timer_state.entry_number;
            timer_state.entry_number = 0;
            timer_state.entry_count = 0;
            if (v > 0) begin
                if (k == KEY_A) begin
                    timer_state.mode = MODE_DOWN;
                    timer_state.cnt_value = v;
                    timer_state.cnt_target = 0;
                end else begin
                    timer_state.mode = MODE_UP;
                    timer_state.cnt_value = 0;
                    timer_state.cnt_target = v;
                end
                timer_state.flash_idx = 0;
                step_display(timer_state.cnt_value);
            end
        end
        timer_state.key_valid = 1'b1;
        timer_state.key_prev = k;
        timer_state.since_key = 0;
    endfunction

    // Millisecond tick: key timer, count steps and flash halves.
    function automatic void predict_tick();
        int limit;
        if (timer_state.since_key < int'(SINCE_MAX)) timer_state.since_key++;
        if (timer_state.mode == MODE_IDLE) return;
        limit = (timer_state.mode == MODE_FLASH) ? int'(timing_regs.flash_ticks)
                                                 : int'(timing_regs.step_ticks);
        if (limit == 0) limit = 1;
        timer_state.phase_ticks++;
        if (timer_state.phase_ticks < limit) return;
        timer_state.phase_ticks = 0;
        case (timer_state.mode)
            MODE_DOWN: begin
                if (timer_state.cnt_value > 0) begin
                    timer_state.cnt_value--;
                    step_display(timer_state.cnt_value);
                end else begin
                    enter_flash();
                end
            end
            MODE_UP: begin
                if (timer_state.cnt_value < timer_state.cnt_target) begin
                    timer_state.cnt_value++;
                    step_display(timer_state.cnt_value);
                end else begin
                    enter_flash();
                end
            end
            default: begin
                timer_state.flash_idx++;
                if (timer_state.flash_idx >= 2 * int'(timing_regs.flash_repeats)) begin
                    timer_state.mode = MODE_IDLE;
                    timer_state.flash_idx = 0;
                    show_value(timer_state.cnt_value);
                end else if (timer_state.flash_idx % 2 != 0) begin
                    show_value(timer_state.cnt_value);
                end else begin
                    timer_state.tens = DIGIT_BLANK;
                    timer_state.ones = DIGIT_BLANK;
                end
            end
        endcase
    endfunction

    // Offers one event transaction and records its predicted result.
    task automatic send_event(logic cmd, logic [3:0] code);
        int      gap;
        t_result status;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd;
        item_ch.key_code <= code;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (cmd == CMD_KEY) predict_key(code);
        else predict_tick();
        status.tens_digit = timer_state.tens;
        status.ones_digit = timer_state.ones;
        status.led_on = timer_state.led;
        status.run_mode = timer_state.mode;
        status.entry_digits = 2'(timer_state.entry_count);
        status.entry_value = 7'(timer_state.entry_number);
        predicted_status.push_back(status);
        events_sent++;
    endtask

    // Key press preceded by up to two ticks; a repeated key waits out a debounce below 40 ticks.
    task automatic press_key(logic [3:0] k);
        int gap_ticks;
        gap_ticks = $urandom_range(0, 2);
        if (timer_state.key_valid && timer_state.key_prev == k &&
            timing_regs.debounce_ticks < 16'd40) begin
            gap_ticks = int'(timing_regs.debounce_ticks) + 1;
        end
        repeat (gap_ticks) send_event(CMD_TICK, 4'($urandom_range(0, 15)));
        send_event(CMD_KEY, k);
    endtask

    // Register write, made only once every result in flight has arrived.
    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        item_ch.valid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_STEP_TICKS:     timing_regs.step_ticks = value;
            CFG_FLASH_TICKS:    timing_regs.flash_ticks = value;
            CFG_DEBOUNCE_TICKS: timing_regs.debounce_ticks = value;
            default:            timing_regs.flash_repeats = value[3:0];
        endcase
    endtask

    task automatic set_timing(logic [15:0] step, logic [15:0] flash, logic [15:0] dbn,
                              logic [3:0] reps);
        write_register(CFG_STEP_TICKS, step);
        write_register(CFG_FLASH_TICKS, flash);
        write_register(CFG_DEBOUNCE_TICKS, dbn);
        write_register(CFG_FLASH_REPEATS, 16'(reps));
    endtask

    function automatic t_row event_row(logic cmd, logic [3:0] code, int count);
        t_row r;
        r = '{kind: ROW_EVENT, default: '0};
        r.cmd = cmd;
        r.code = code;
        r.count = count;
        return r;
    endfunction

    function automatic t_row checked_row(logic cmd, logic [3:0] code, logic [3:0] tens,
                                         logic [3:0] ones, logic led, t_mode mode,
                                         logic [1:0] digits, logic [6:0] value);
        t_row r;
        r = event_row(cmd, code, 1);
        r.typed = 1'b1;
        r.want.tens_digit = tens;
        r.want.ones_digit = ones;
        r.want.led_on = led;
        r.want.run_mode = mode;
        r.want.entry_digits = digits;
        r.want.entry_value = value;
        return r;
    endfunction

    function automatic t_row config_row(logic [1:0] idx, logic [15:0] value);
        t_row r;
        r = '{kind: ROW_CONFIG, default: '0};
        r.reg_idx = idx;
        r.reg_data = value;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Compares one result transaction with the oldest prediction.
    task automatic check_result();
        t_result want;
        if (predicted_status.size() == 0) begin
            $error("result transaction with no prediction waiting");
            failures++;
            return;
        end
        want = predicted_status.pop_front();
        check_field("tens_digit", want.tens_digit, res_ch.tens_digit);
        check_field("ones_digit", want.ones_digit, res_ch.ones_digit);
        check_field("led_on", want.led_on, res_ch.led_on);
        check_field("run_mode", want.run_mode, res_ch.run_mode);
        check_field("entry_digits", want.entry_digits, res_ch.entry_digits);
        check_field("entry_value", want.entry_value, res_ch.entry_value);
    endtask

    // Result side: random stalls, one long hold-off, checking of each transaction.
    initial begin : result_sink
        int stall_left;
        int taken;
        bit held;
        stall_left = 0;
        taken = 0;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                check_result();
                taken++;
            end
            if (!held && taken >= HOLD_AT_RESULT) begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (!burst_mode && $urandom_range(0, 99) < 25) begin
                res_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus: directed table, then random phases.
    initial begin : stimulus
        t_row       stim_table[$];
        int         next_phase_at;
        int         random_base;
        int         phase;
        int         r;
        int         value;
        int         n;
        int         tick_cap;
        logic [3:0] k;
        logic [15:0] dbn;

        i_rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.command <= CMD_KEY;
        item_ch.key_code <= 4'd0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_STEP_TICKS;
        cfg_ch.data <= 16'd0;

        // Model state after reset.
        timer_state = '{mode: MODE_IDLE, default: 0};
        timer_state.mode = MODE_IDLE;
        timer_state.tens = DIGIT_BLANK;
        timer_state.ones = DIGIT_BLANK;
        timing_regs.step_ticks = STEP_TICKS_RST;
        timing_regs.flash_ticks = FLASH_TICKS_RST;
        timing_regs.debounce_ticks = DEBOUNCE_TICKS_RST;
        timing_regs.flash_repeats = FLASH_REPEATS_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Entry handling under the reset timing.
        stim_table.push_back(checked_row(CMD_TICK, 4'd0, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd0, 7'd0));
        stim_table.push_back(checked_row(CMD_KEY, 4'd9, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd1, 7'd9));
        // The same key at once is filtered out.
        stim_table.push_back(checked_row(CMD_KEY, 4'd9, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd1, 7'd9));
        stim_table.push_back(checked_row(CMD_KEY, 4'd0, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd2, 7'd90));
        // A third digit is dropped.
        stim_table.push_back(checked_row(CMD_KEY, 4'd5, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd2, 7'd90));
        stim_table.push_back(checked_row(CMD_KEY, KEY_C, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd2, 7'd90));
        stim_table.push_back(event_row(CMD_KEY, KEY_D, 1));
        stim_table.push_back(event_row(CMD_KEY, KEY_STAR, 1));
        stim_table.push_back(checked_row(CMD_KEY, KEY_HASH, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd0, 7'd0));
        // Start with an empty entry, then start with a zero entry.
        stim_table.push_back(checked_row(CMD_KEY, KEY_A, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd0, 7'd0));
        stim_table.push_back(checked_row(CMD_KEY, 4'd0, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd1, 7'd0));
        stim_table.push_back(checked_row(CMD_KEY, KEY_B, DIGIT_BLANK, DIGIT_BLANK, 1'b0,
                                         MODE_IDLE, 2'd0, 7'd0));
        // Fast timing for the counting cases.
        stim_table.push_back(config_row(CFG_STEP_TICKS, 16'd2));
        stim_table.push_back(config_row(CFG_FLASH_TICKS, 16'd1));
        stim_table.push_back(config_row(CFG_DEBOUNCE_TICKS, 16'd0));
        stim_table.push_back(config_row(CFG_FLASH_REPEATS, 16'd1));
        stim_table.push_back(event_row(CMD_KEY, 4'd1, 1));
        stim_table.push_back(event_row(CMD_KEY, 4'd2, 1));
        // Countdown start shows the first value and toggles the LED at once.
        stim_table.push_back(checked_row(CMD_KEY, KEY_A, 4'd1, 4'd2, 1'b1,
                                         MODE_DOWN, 2'd0, 7'd0));
        stim_table.push_back(event_row(CMD_TICK, 4'd0, 3));
        // A count-up replaces the running countdown and runs through its flash.
        stim_table.push_back(event_row(CMD_KEY, 4'd5, 1));
        stim_table.push_back(event_row(CMD_KEY, KEY_B, 1));
        stim_table.push_back(event_row(CMD_TICK, 4'hF, 20));
        // With no debounce a repeat needs one tick in between.
        stim_table.push_back(event_row(CMD_KEY, 4'd1, 2));
        stim_table.push_back(event_row(CMD_TICK, 4'd6, 1));
        stim_table.push_back(event_row(CMD_KEY, 4'd1, 1));
        stim_table.push_back(event_row(CMD_KEY, KEY_A, 1));
        stim_table.push_back(event_row(CMD_TICK, 4'd9, 40));

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CONFIG) begin
                write_register(stim_table[i].reg_idx, stim_table[i].reg_data);
            end else begin
                repeat (stim_table[i].count) begin
                    send_event(stim_table[i].cmd, stim_table[i].code);
                    if (stim_table[i].typed) begin
                        predicted_status[predicted_status.size() - 1] = stim_table[i].want;
                    end
                end
            end
        end

        // Random phases, each with its own timing.
        phase = 0;
        random_base = events_sent;
        next_phase_at = events_sent;
        while (events_sent - random_base < RANDOM_EVENTS) begin
            if (events_sent >= next_phase_at) begin
                case (phase)
                    0: set_timing(SINCE_MAX, 16'd1, 16'd0, 4'd15);
                    1: set_timing(16'd1, SINCE_MAX, SINCE_MAX, 4'd1);
                    2: set_timing(16'd1, 16'd1, 16'd0, 4'd1);
                    default: begin
                        r = $urandom_range(0, 3);
                        dbn = (r == 0) ? 16'd0 :
                              (r == 1) ? 16'($urandom_range(9, 40)) :
                                         16'($urandom_range(1, 8));
                        set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                                   dbn, 4'($urandom_range(1, 15)));
                    end
                endcase
                burst_mode = ($urandom_range(0, 3) == 0);
                next_phase_at = events_sent + PHASE_EVENTS;
                phase++;
            end

            r = $urandom_range(0, 99);
            if (r < 70) begin
                // Well-formed entry, start and count, sometimes cut short.
                if ($urandom_range(0, 3) == 0) press_key(KEY_HASH);
                r = $urandom_range(0, 99);
                if (r < 55) value = $urandom_range(1, 9);
                else if (r < 85) value = $urandom_range(10, 30);
                else if (r < 95) value = $urandom_range(90, 99);
                else value = 0;
                if (value >= 10 || $urandom_range(0, 2) == 0) press_key(4'(value / 10));
                press_key(4'(value % 10));
                if ($urandom_range(0, 4) == 0) press_key(4'($urandom_range(12, 14)));
                press_key(($urandom_range(0, 1) == 0) ? KEY_A : KEY_B);
                if ($urandom_range(0, 4) == 0) tick_cap = $urandom_range(0, 30);
                else if (phase <= 2) tick_cap = 60;
                else tick_cap = 2000;
                n = 0;
                while (timer_state.mode != MODE_IDLE && n < tick_cap) begin
                    send_event(CMD_TICK, 4'($urandom_range(0, 15)));
                    n++;
                    if ($urandom_range(0, 40) == 0) begin
                        send_event(CMD_KEY, 4'($urandom_range(0, 15)));
                    end
                end
            end else if (r < 85) begin
                // Noise.
                repeat ($urandom_range(1, 8)) begin
                    send_event(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                end
            end else begin
                // Same key around the debounce boundary.
                k = 4'($urandom_range(0, 15));
                send_event(CMD_KEY, k);
                if (timing_regs.debounce_ticks <= 16'd40) begin
                    n = int'(timing_regs.debounce_ticks) + $urandom_range(0, 2) - 1;
                    if (n < 0) n = 0;
                end else begin
                    n = $urandom_range(0, 5);
                end
                repeat (n) send_event(CMD_TICK, 4'($urandom_range(0, 15)));
                send_event(CMD_KEY, k);
            end
        end

        // Drain the results still in flight.
        item_ch.valid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
